// ===== src/particle_half_boris_push_macros.svh =====
// assertion macros for the half-step particle pusher
`ifndef PARTICLE_HALF_BORIS_PUSH_MACROS_SVH
`define PARTICLE_HALF_BORIS_PUSH_MACROS_SVH

// same-cycle implication
`define PHBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PHBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/phbp_pkg.sv =====
// types, constants and stage arithmetic for the half-step particle pusher
`timescale 1ns / 1ps

package phbp_pkg;

  localparam int unsigned VOXELS_DEFAULT = 4096;
  localparam int unsigned NUM_COEFS = 18;

  typedef logic signed [31:0] q_t;
  typedef q_t [2:0] q3_t;
  typedef logic [2:0][63:0] w3_t;

  localparam q_t Q_ONE = 32'sd16777216;
  localparam q_t Q_THIRD = 32'sd5592405;
  localparam q_t Q_TWO_FIFTEENTHS = 32'sd2236962;
  localparam logic signed [63:0] QMAX64 = 64'sd2147483647;
  localparam logic signed [63:0] QMIN64 = -64'sd2147483648;
  localparam logic signed [63:0] QHALF64 = 64'sd8388608;

  localparam int unsigned ISQ_STEPS = 32;
  localparam int unsigned DV1_STEPS = 49;
  localparam int unsigned DV2_STEPS = 25;

  localparam int unsigned ST_L1 = 2;
  localparam int unsigned ST_L2 = 3;
  localparam int unsigned ST_L3 = 4;
  localparam int unsigned ST_L4 = 5;
  localparam int unsigned ST_SQR = 6;
  localparam int unsigned ST_SUM = 7;
  localparam int unsigned ST_ISQ = 8;
  localparam int unsigned ST_ISQ_LAST = ST_ISQ + ISQ_STEPS - 1;
  localparam int unsigned ST_DV1 = ST_ISQ + ISQ_STEPS;
  localparam int unsigned ST_V00A = ST_DV1 + DV1_STEPS;
  localparam int unsigned ST_V00 = ST_V00A + 1;
  localparam int unsigned ST_T = ST_V00 + 1;
  localparam int unsigned ST_V02 = ST_T + 1;
  localparam int unsigned ST_W1 = ST_V02 + 1;
  localparam int unsigned ST_W2 = ST_W1 + 1;
  localparam int unsigned ST_V03 = ST_W2 + 1;
  localparam int unsigned ST_X1M = ST_V03 + 1;
  localparam int unsigned ST_X1S = ST_X1M + 1;
  localparam int unsigned ST_DEN = ST_X1S + 1;
  localparam int unsigned ST_P = ST_DEN + 1;
  localparam int unsigned ST_X2M = ST_P + 1;
  localparam int unsigned ST_X2S = ST_X2M + 1;
  localparam int unsigned ST_DV2 = ST_X2S + 1;
  localparam int unsigned ST_V04M = ST_DV2 + DV2_STEPS;
  localparam int unsigned ST_V04 = ST_V04M + 1;
  localparam int unsigned ST_M = ST_V04 + 1;
  localparam int unsigned ST_OUT = ST_M + 1;
  localparam int unsigned PIPE_DEPTH = ST_OUT;

  typedef struct packed {
    logic             vox_ok;
    q_t [17:0]        f;
    q3_t              d;
    q3_t              u;
    q3_t              a1;
    q3_t              a2;
    q3_t              e1;
    q3_t              e0;
    q3_t              b;
    q3_t              ha;
    q3_t              sb;
    q3_t              cm1;
    q3_t              cm2;
    q3_t              c;
    q3_t              pm;
    q3_t              pp;
    w3_t              sq;
    logic [63:0]      rem;
    logic [63:0]      res;
    logic [32:0]      drem;
    logic [48:0]      r;
    logic signed [63:0] plo;
    logic signed [63:0] phi;
    q_t               v01;
    q_t               v00;
    q_t               t;
    q_t               v02;
    q_t               w1;
    q_t               w2;
    q_t               v03;
    q_t               t2;
    q_t               t3;
    q_t               den;
    q_t               v04;
  } pl_t;

  function automatic q_t qsat(input logic signed [63:0] v);
    q_t res;
    if (v > QMAX64) begin
      res = q_t'(QMAX64[31:0]);
    end else if (v < QMIN64) begin
      res = q_t'(QMIN64[31:0]);
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic q_t qround(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + QHALF64;
    return qsat(s >>> 24);
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return qround(p);
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    return qsat(s);
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [63:0] s;
    s = 64'(a) - 64'(b);
    return qsat(s);
  endfunction

  function automatic logic [63:0] sqr(input q_t a);
    logic signed [63:0] p;
    p = 64'(a) * 64'(a);
    return p;
  endfunction

  function automatic logic [1:0] nx1(input int unsigned i);
    return (i == 2) ? 2'd0 : 2'(i + 1);
  endfunction

  function automatic logic [1:0] nx2(input int unsigned i);
    return (i == 0) ? 2'd2 : 2'(i - 1);
  endfunction

  // one pipeline stage, picked by its position
  function automatic pl_t stage_op(input int unsigned k, input pl_t p, input q_t qm);
    pl_t n;
    q_t qh;
    logic [63:0] tb;
    logic [63:0] trial;
    logic [32:0] dr;
    logic signed [63:0] prod;
    int unsigned st;
    n = p;
    qh = qm >>> 1;
    if (k == ST_L1) begin
      for (int i = 0; i < 3; i++) begin
        n.a1[i] = qmul(p.d[nx1(i)], p.f[4*i+3]);
        n.a2[i] = qmul(p.d[nx1(i)], p.f[4*i+1]);
        n.b[i] = qmul(p.f[13+2*i], p.d[i]);
      end
    end else if (k == ST_L2) begin
      for (int i = 0; i < 3; i++) begin
        n.e1[i] = qmul(qadd(p.a1[i], p.f[4*i+2]), p.d[nx2(i)]);
        n.e0[i] = qadd(p.a2[i], p.f[4*i]);
        n.b[i] = qadd(p.b[i], p.f[12+2*i]);
      end
    end else if (k == ST_L3) begin
      for (int i = 0; i < 3; i++) begin
        n.ha[i] = qmul(qm, qadd(p.e1[i], p.e0[i]));
        n.sb[i] = qmul(p.b[i], p.b[i]);
      end
    end else if (k == ST_L4) begin
      for (int i = 0; i < 3; i++) begin
        n.u[i] = qadd(p.u[i], p.ha[i]);
      end
      n.v01 = qadd(qadd(p.sb[0], p.sb[1]), p.sb[2]);
    end else if (k == ST_SQR) begin
      for (int i = 0; i < 3; i++) begin
        n.sq[i] = sqr(p.u[i]);
      end
    end else if (k == ST_SUM) begin
      n.rem = 64'h0001_0000_0000_0000 + p.sq[0] + p.sq[1] + p.sq[2];
      n.res = '0;
      n.drem = '0;
      n.r = '0;
    end else if (k >= ST_ISQ && k < ST_DV1) begin
      st = k - ST_ISQ;
      tb = 64'd1 << (62 - 2 * st);
      trial = p.res + tb;
      if (p.rem >= trial) begin
        n.rem = p.rem - trial;
        n.res = (p.res >> 1) + tb;
      end else begin
        n.res = p.res >> 1;
      end
    end else if (k >= ST_DV1 && k < ST_V00A) begin
      st = k - ST_DV1;
      dr = {p.drem[31:0], (st == 0) ? 1'b1 : 1'b0};
      if (dr >= {1'b0, p.res[31:0]}) begin
        n.drem = dr - {1'b0, p.res[31:0]};
        n.r = {p.r[47:0], 1'b1};
      end else begin
        n.drem = dr;
        n.r = {p.r[47:0], 1'b0};
      end
    end else if (k == ST_V00A) begin
      n.plo = 64'(qh) * 64'($signed({1'b0, p.r[23:0]}));
      n.phi = 64'(qh) * 64'($signed({1'b0, p.r[48:24]}));
    end else if (k == ST_V00) begin
      prod = p.plo + (p.phi <<< 24);
      n.v00 = qround(prod);
    end else if (k == ST_T) begin
      n.t = qmul(p.v00, p.v00);
    end else if (k == ST_V02) begin
      n.v02 = qmul(p.t, p.v01);
    end else if (k == ST_W1) begin
      n.w1 = qmul(p.v02, Q_TWO_FIFTEENTHS);
    end else if (k == ST_W2) begin
      n.w2 = qmul(p.v02, qadd(p.w1, Q_THIRD));
    end else if (k == ST_V03) begin
      n.v03 = qmul(p.v00, qadd(p.w2, Q_ONE));
    end else if (k == ST_X1M) begin
      n.t2 = qmul(p.v03, p.v03);
      for (int i = 0; i < 3; i++) begin
        n.cm1[i] = qmul(p.u[nx1(i)], p.b[nx2(i)]);
        n.cm2[i] = qmul(p.u[nx2(i)], p.b[nx1(i)]);
      end
    end else if (k == ST_X1S || k == ST_X2S) begin
      if (k == ST_X1S) begin
        n.t3 = qmul(p.t2, p.v01);
      end
      for (int i = 0; i < 3; i++) begin
        n.c[i] = qsub(p.cm1[i], p.cm2[i]);
      end
    end else if (k == ST_DEN) begin
      n.den = qadd(p.t3, Q_ONE);
      for (int i = 0; i < 3; i++) begin
        n.pm[i] = qmul(p.c[i], p.v03);
      end
      n.drem = 33'd8388608;
      n.r = '0;
    end else if (k == ST_P) begin
      for (int i = 0; i < 3; i++) begin
        n.pp[i] = qadd(p.pm[i], p.u[i]);
      end
    end else if (k == ST_X2M) begin
      for (int i = 0; i < 3; i++) begin
        n.cm1[i] = qmul(p.pp[nx1(i)], p.b[nx2(i)]);
        n.cm2[i] = qmul(p.pp[nx2(i)], p.b[nx1(i)]);
      end
    end else if (k >= ST_DV2 && k < ST_V04M) begin
      dr = {p.drem[31:0], 1'b0};
      if (dr >= {1'b0, p.den}) begin
        n.drem = dr - {1'b0, p.den};
        n.r = {p.r[47:0], 1'b1};
      end else begin
        n.drem = dr;
        n.r = {p.r[47:0], 1'b0};
      end
    end else if (k == ST_V04M) begin
      n.v04 = qmul(p.v03, q_t'({7'd0, p.r[24:0]}));
    end else if (k == ST_V04) begin
      n.v04 = qadd(p.v04, p.v04);
    end else if (k == ST_M) begin
      for (int i = 0; i < 3; i++) begin
        n.pm[i] = qmul(p.c[i], p.v04);
      end
    end else if (k == ST_OUT) begin
      for (int i = 0; i < 3; i++) begin
        n.u[i] = qadd(p.pm[i], p.u[i]);
      end
    end
    return n;
  endfunction

endpackage

// ===== src/phbp_ram.sv =====
// generic single-write, registered-read RAM
`timescale 1ns / 1ps

module phbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/particle_half_boris_push.sv =====
// Half-step Boris particle pusher: one push request enters per clock while in_ready is
// high; the pipeline depth comes from the one-bit-per-stage square root (32 stages)
// and the two restoring dividers (49 and 25 stages) between the Q8.24 multiply
// stages. A coefficient write request lands in one of 18 per-slot field RAMs and
// gives no result. A stage holds only while it and every stage after it are full and
// out_ready is low, so bubbles close up and a waiting result stops new requests only
// once every stage holds a push.
`timescale 1ns / 1ps
`include "particle_half_boris_push_macros.svh"

module particle_half_boris_push #(
  parameter int unsigned VOXELS = phbp_pkg::VOXELS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [11:0] voxel,
  input  logic [4:0]  coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_z,
  input  logic signed [31:0] mom_x,
  input  logic signed [31:0] mom_y,
  input  logic signed [31:0] mom_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] new_mom_x,
  output logic signed [31:0] new_mom_y,
  output logic signed [31:0] new_mom_z
);

  localparam int unsigned NST = phbp_pkg::PIPE_DEPTH;
  localparam int unsigned NC = phbp_pkg::NUM_COEFS;
  localparam int unsigned AW = (VOXELS > 1) ? $clog2(VOXELS) : 1;

  phbp_pkg::q_t qm;
  phbp_pkg::pl_t pipe [1:NST];
  phbp_pkg::pl_t cap;
  phbp_pkg::pl_t pin;
  logic [NST:1] v;
  logic [NST:1] en;
  logic vox_ok;
  logic wr_req;
  logic [AW-1:0] addr;
  logic [31:0] rdata [NC];

  always_ff @(posedge clk) begin
    if (rst) begin
      qm <= '0;
    end else if (cfg_wr_en) begin
      qm <= cfg_wr_data;
    end
  end

  assign vox_ok = {5'd0, voxel} < 17'(VOXELS);
  assign addr = AW'(voxel);
  assign wr_req = in_valid && in_ready && !command && vox_ok;

  // field table, one RAM per coefficient slot
  for (genvar j = 0; j < NC; j++) begin : g_coef
    phbp_ram #(
      .WIDTH(32),
      .DEPTH(VOXELS)
    ) u_ram (
      .clk  (clk),
      .we   (wr_req && (coef_index == 5'(j))),
      .waddr(addr),
      .wdata(coef_value),
      .re   (en[1]),
      .raddr(addr),
      .rdata(rdata[j])
    );
  end

  for (genvar k = 1; k <= NST; k++) begin : g_en
    assign en[k] = out_ready || !(&v[NST:k]);
  end
  assign in_ready = en[1];

  always_comb begin
    cap = '0;
    cap.vox_ok = vox_ok;
    cap.d[0] = offset_x;
    cap.d[1] = offset_y;
    cap.d[2] = offset_z;
    cap.u[0] = mom_x;
    cap.u[1] = mom_y;
    cap.u[2] = mom_z;
  end

  always_comb begin
    pin = pipe[1];
    for (int j = 0; j < NC; j++) begin
      pin.f[j] = pipe[1].vox_ok ? rdata[j] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pipe[1] <= cap;
    end
  end

  for (genvar k = 2; k <= NST; k++) begin : g_st
    phbp_pkg::pl_t prev;
    if (k == 2) begin : g_first
      assign prev = pin;
    end else begin : g_rest
      assign prev = pipe[k-1];
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        pipe[k] <= phbp_pkg::stage_op(k, prev, qm);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid && command;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign out_valid = v[NST];
  assign new_mom_x = pipe[NST].u[0];
  assign new_mom_y = pipe[NST].u[1];
  assign new_mom_z = pipe[NST].u[2];

  `PHBP_ASSERT_NOW(a_ready_when_free, clk, rst, !out_valid || out_ready, in_ready, "input blocked with output free")
  `PHBP_ASSERT_NEXT(a_write_no_result, clk, rst, in_valid && in_ready && !command, !v[1], "write request entered the pipeline")
  `PHBP_ASSERT_NOW(a_root_width, clk, rst, v[phbp_pkg::ST_ISQ_LAST], pipe[phbp_pkg::ST_ISQ_LAST].res[63:32] == 32'd0, "square root wider than 32 bits")
  `PHBP_ASSERT_NOW(a_den_floor, clk, rst, v[phbp_pkg::ST_DEN], $signed(pipe[phbp_pkg::ST_DEN].den) >= phbp_pkg::Q_ONE, "rotation denominator below one")

endmodule
